// File: sv/szcls_pkg.sv
`timescale 1ns / 1ps

package szcls_pkg;

    localparam int SIZE_W = 14;
    localparam int BEST_W = SIZE_W + 1;

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [BEST_W-1:0] best_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam size_t MIN_REQUEST = 14'd24;

    localparam int NUM_PREF = 11;
    localparam logic [7:0] PREF_SIZES [NUM_PREF] =
        '{8'd24, 8'd32, 8'd40, 8'd48, 8'd56, 8'd64, 8'd72, 8'd88, 8'd104, 8'd120, 8'd152};

    // floor(2^k * 500 / 707) rounded up to a multiple of 8, k = 0..14
    localparam int NUM_POW = 15;
    localparam size_t HALF_STEP [NUM_POW] =
        '{14'd0, 14'd8, 14'd8, 14'd8, 14'd16, 14'd24, 14'd48, 14'd96, 14'd184,
          14'd368, 14'd728, 14'd1448, 14'd2896, 14'd5800, 14'd11592};

    // search beat walking along the cell row
    typedef struct packed {
        logic       active;
        logic [1:0] status;
        logic       best_ovf;
        size_t      req;
        size_t      best;
        logic       hit_req;
        logic       hit_best;
    } probe_t;

    typedef struct packed {
        logic  en;
        size_t size;
    } wr_t;

    function automatic best_t best_size(input size_t req);
        best_t p;
        best_t half;
        best_t pf;
        best_t best;
        logic  pf_ok;
        best_t req_w;
        req_w = {1'b0, req};
        p     = best_t'(1) << (NUM_POW - 1);
        half  = {1'b0, HALF_STEP[NUM_POW-1]};
        for (int k = NUM_POW - 1; k >= 0; k--) begin
            if ((best_t'(1) << k) >= req_w) begin
                p    = best_t'(1) << k;
                half = {1'b0, HALF_STEP[k]};
            end
        end
        best  = (half >= req_w) ? half : p;
        pf_ok = 1'b0;
        pf    = '0;
        for (int i = NUM_PREF - 1; i >= 0; i--) begin
            if ({7'b0, PREF_SIZES[i]} >= req_w) begin
                pf    = {7'b0, PREF_SIZES[i]};
                pf_ok = 1'b1;
            end
        end
        if (pf_ok && (pf < best))
            best = pf;
        return best;
    endfunction

endpackage

// File: sv/szcls_cell.sv
`timescale 1ns / 1ps

module szcls_cell #(
    parameter int IDX_W = 4,
    parameter int SLOT  = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  szcls_pkg::probe_t     probe_in,
    input  logic [IDX_W-1:0]      req_idx_in,
    input  logic [IDX_W-1:0]      best_idx_in,
    input  szcls_pkg::wr_t        wr,
    input  logic [IDX_W-1:0]      wr_slot,
    output szcls_pkg::probe_t     probe_out,
    output logic [IDX_W-1:0]      req_idx_out,
    output logic [IDX_W-1:0]      best_idx_out
);

    szcls_pkg::size_t  size_reg;
    logic              valid_reg;
    szcls_pkg::probe_t probe_reg, probe_next;
    logic [IDX_W-1:0]  req_idx_reg, req_idx_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic              wr_here;

    assign wr_here = wr.en && (wr_slot == IDX_W'(SLOT));

    always_comb
    begin
        probe_next    = probe_in;
        req_idx_next  = req_idx_in;
        best_idx_next = best_idx_in;
        // first matching slot wins
        if (probe_in.active && valid_reg && !probe_in.hit_req && (size_reg == probe_in.req))
        begin
            probe_next.hit_req = 1'b1;
            req_idx_next       = IDX_W'(SLOT);
        end
        if (probe_in.active && valid_reg && !probe_in.hit_best
            && (size_reg == probe_in.best))
        begin
            probe_next.hit_best = 1'b1;
            best_idx_next       = IDX_W'(SLOT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (wr_here)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        req_idx_reg  <= req_idx_next;
        best_idx_reg <= best_idx_next;
        if (wr_here)
            size_reg <= wr.size;
    end

    assign probe_out    = probe_reg;
    assign req_idx_out  = req_idx_reg;
    assign best_idx_out = best_idx_reg;

endmodule

// File: sv/size_class_selector_unit.sv
`timescale 1ns / 1ps
// Each request beat is registered at the input and walks the row of category cells one cell
// per cycle, and the table is updated as it leaves the row; a new request is taken only
// after the previous result has moved into the output register.
// A finished result may wait in the output register while the next request is taken.
// Reset (rst_n, asynchronous, active low) empties the category table and all valid flags.

module size_class_selector_unit #(
    parameter int MAX_CATEGORIES  = 16,
    parameter int MAX_OBJECT_SIZE = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        request_valid,
    output logic        request_stall,
    input  logic [13:0] request_size,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [3:0]  category_index,
    output logic [13:0] category_size,
    output logic        was_created,
    output logic [1:0]  status
);

    localparam int IDX_W = $clog2(MAX_CATEGORIES);
    localparam int CNT_W = $clog2(MAX_CATEGORIES + 1);

    szcls_pkg::probe_t probe_chain [MAX_CATEGORIES+1];
    logic [IDX_W-1:0]  req_idx_chain [MAX_CATEGORIES+1];
    logic [IDX_W-1:0]  best_idx_chain [MAX_CATEGORIES+1];

    szcls_pkg::probe_t probe0_reg, probe0_next;
    szcls_pkg::probe_t tail;
    szcls_pkg::best_t  best_w;
    szcls_pkg::wr_t    wr;
    logic [IDX_W-1:0]  wr_slot;

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    szcls_pkg::size_t  res_size_reg, res_size_next;
    logic              res_created_reg, res_created_next;
    logic [1:0]        res_status_reg, res_status_next;

    logic              out_valid_reg, out_valid_next;
    logic [3:0]        out_idx_reg, out_idx_next;
    szcls_pkg::size_t  out_size_reg, out_size_next;
    logic              out_created_reg, out_created_next;
    logic [1:0]        out_status_reg, out_status_next;

    logic              accept;
    logic              out_free;
    logic              move_out;
    logic              table_full;
    logic [IDX_W+3:0]  idx_ext;

    assign accept   = request_valid && !busy_reg;
    assign out_free = !out_valid_reg || !result_stall;
    assign move_out = pend_reg && out_free;
    assign best_w   = szcls_pkg::best_size(request_size);

    always_comb
    begin
        probe0_next          = '0;
        probe0_next.active   = accept;
        probe0_next.req      = request_size;
        probe0_next.best     = best_w[szcls_pkg::SIZE_W-1:0];
        probe0_next.best_ovf = best_w[szcls_pkg::SIZE_W];
        if (request_size < szcls_pkg::MIN_REQUEST)
            probe0_next.status = szcls_pkg::ST_BELOW;
        else if ({1'b0, request_size} > szcls_pkg::BEST_W'(MAX_OBJECT_SIZE))
            probe0_next.status = szcls_pkg::ST_ABOVE;
        else
            probe0_next.status = szcls_pkg::ST_OK;
    end

    assign probe_chain[0]    = probe0_reg;
    assign req_idx_chain[0]  = '0;
    assign best_idx_chain[0] = '0;

    for (genvar g = 0; g < MAX_CATEGORIES; g++)
    begin : g_cell
        szcls_cell #(
            .IDX_W (IDX_W),
            .SLOT  (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .probe_in     (probe_chain[g]),
            .req_idx_in   (req_idx_chain[g]),
            .best_idx_in  (best_idx_chain[g]),
            .wr           (wr),
            .wr_slot      (wr_slot),
            .probe_out    (probe_chain[g+1]),
            .req_idx_out  (req_idx_chain[g+1]),
            .best_idx_out (best_idx_chain[g+1])
        );
    end

    assign tail       = probe_chain[MAX_CATEGORIES];
    assign table_full = count_reg >= CNT_W'(MAX_CATEGORIES);
    assign wr_slot    = count_reg[IDX_W-1:0];

    // resolve the beat leaving the row
    always_comb
    begin
        res_idx_next     = res_idx_reg;
        res_size_next    = res_size_reg;
        res_created_next = res_created_reg;
        res_status_next  = res_status_reg;
        pend_next        = pend_reg && !move_out;
        count_next       = count_reg;
        wr.en            = 1'b0;
        wr.size          = tail.best;
        if (tail.active)
        begin
            pend_next        = 1'b1;
            res_idx_next     = '0;
            res_size_next    = '0;
            res_created_next = 1'b0;
            res_status_next  = szcls_pkg::ST_OK;
            if (tail.status != szcls_pkg::ST_OK)
                res_status_next = tail.status;
            else if (tail.hit_req)
            begin
                res_idx_next  = req_idx_chain[MAX_CATEGORIES];
                res_size_next = tail.req;
            end
            else if (tail.best_ovf)
                res_status_next = szcls_pkg::ST_ABOVE;
            else if (tail.hit_best)
            begin
                res_idx_next  = best_idx_chain[MAX_CATEGORIES];
                res_size_next = tail.best;
            end
            else if (table_full)
                res_status_next = szcls_pkg::ST_FULL;
            else
            begin
                wr.en            = 1'b1;
                res_idx_next     = wr_slot;
                res_size_next    = tail.best;
                res_created_next = 1'b1;
                count_next       = count_reg + CNT_W'(1);
            end
        end
    end

    assign idx_ext = {4'b0, res_idx_reg};

    always_comb
    begin
        busy_next        = busy_reg;
        out_valid_next   = out_valid_reg && result_stall;
        out_idx_next     = out_idx_reg;
        out_size_next    = out_size_reg;
        out_created_next = out_created_reg;
        out_status_next  = out_status_reg;
        if (accept)
            busy_next = 1'b1;
        if (move_out)
        begin
            busy_next        = 1'b0;
            out_valid_next   = 1'b1;
            out_idx_next     = idx_ext[3:0];
            out_size_next    = res_size_reg;
            out_created_next = res_created_reg;
            out_status_next  = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe0_reg    <= '0;
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            probe0_reg    <= probe0_next;
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_idx_reg     <= res_idx_next;
        res_size_reg    <= res_size_next;
        res_created_reg <= res_created_next;
        res_status_reg  <= res_status_next;
        out_idx_reg     <= out_idx_next;
        out_size_reg    <= out_size_next;
        out_created_reg <= out_created_next;
        out_status_reg  <= out_status_next;
    end

    assign request_stall  = busy_reg;
    assign result_valid   = out_valid_reg;
    assign category_index = out_idx_reg;
    assign category_size  = out_size_reg;
    assign was_created    = out_created_reg;
    assign status         = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CATEGORIES))
        else $error("category count beyond table depth");

    a_created_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_created_reg |-> out_status_reg == szcls_pkg::ST_OK)
        else $error("created beat carries an error status");

    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> busy_reg && !pend_reg)
        else $error("beat left the cell row while idle or with a result pending");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("table write without count step");

    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        probe0_reg.active |-> !pend_reg && !tail.active)
        else $error("two beats in flight");
`endif

endmodule

// File: sim/size_class_selector_unit_tb.sv
`timescale 1ns / 1ps

module size_class_selector_unit_tb;

    localparam int MAX_CATEGORIES  = 16;
    localparam int MAX_OBJECT_SIZE = 8192;
    localparam int RANDOM_ITEMS    = 650;
    localparam int DRAIN_CYCLES    = 2 * (MAX_CATEGORIES + 3);
    localparam int CYCLE_LIMIT     = 400000;
    localparam int IDLE_PERCENT    = 23;

    localparam int NUM_FIT = 11;
    localparam int FIT_SIZES [NUM_FIT] = '{24, 32, 40, 48, 56, 64, 72, 88, 104, 120, 152};

    // upper edges of most size classes reachable up to and including the maximum
    localparam int NUM_EDGES = 23;
    localparam int CLASS_EDGES [NUM_EDGES] = '{24, 32, 40, 48, 56, 64, 72, 88, 104, 120, 152,
        184, 256, 368, 512, 728, 1024, 1448, 2048, 2896, 4096, 5800, 8192};

    typedef struct packed {
        logic [3:0]  index;
        logic [13:0] size;
        logic        created;
        logic [1:0]  status;
    } category_result_t;

    logic        clk;
    logic        rst_n;
    logic        request_valid;
    logic        request_stall;
    logic [13:0] request_size;
    logic        result_valid;
    logic        result_stall;
    logic [3:0]  category_index;
    logic [13:0] category_size;
    logic        was_created;
    logic [1:0]  status;

    // predictor copy of the category table
    logic [13:0] cat_sizes [MAX_CATEGORIES];
    logic        cat_valid [MAX_CATEGORIES];
    int          cat_count;

    category_result_t pending_results [$];

    int  fail_count;
    int  cycle_count;
    int  request_count;
    int  created_count;
    int  status_count [4];
    logic steady;

    size_class_selector_unit #(
        .MAX_CATEGORIES  (MAX_CATEGORIES),
        .MAX_OBJECT_SIZE (MAX_OBJECT_SIZE)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_stall  (request_stall),
        .request_size   (request_size),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .category_index (category_index),
        .category_size  (category_size),
        .was_created    (was_created),
        .status         (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int find_category(input int sz);
        int slot;
        slot = -1;
        for (int i = MAX_CATEGORIES - 1; i >= 0; i--)
        begin
            if (cat_valid[i] && cat_sizes[i] == sz)
                slot = i;
        end
        return slot;
    endfunction

    function automatic int best_fit(input int req);
        int k;
        int pow2;
        int mid;
        int best;
        k = 0;
        while (k < 14 && (1 << k) < req)
            k++;
        pow2 = 1 << k;
        // pow2 / 1.414, truncated, then up to the next multiple of 8
        mid  = ((pow2 * 500 / 707 + 7) / 8) * 8;
        best = (mid >= req) ? mid : pow2;
        for (int i = 0; i < NUM_FIT; i++)
        begin
            if (FIT_SIZES[i] >= req)
            begin
                if (FIT_SIZES[i] < best)
                    best = FIT_SIZES[i];
                break;
            end
        end
        return best;
    endfunction

    function automatic category_result_t predict_category(input logic [13:0] req);
        category_result_t r;
        int slot;
        int best;
        int best_slot;
        r = '0;
        slot = find_category(req);
        best = best_fit(req);
        best_slot = find_category(best);
        if (req < szcls_pkg::MIN_REQUEST)
            r.status = szcls_pkg::ST_BELOW;
        else if (req > MAX_OBJECT_SIZE)
            r.status = szcls_pkg::ST_ABOVE;
        else if (slot >= 0)
        begin
            r.index = slot[3:0];
            r.size  = req;
        end
        else if (best > 16383)
            r.status = szcls_pkg::ST_ABOVE;
        else if (best_slot >= 0)
        begin
            r.index = best_slot[3:0];
            r.size  = best[13:0];
        end
        else if (cat_count >= MAX_CATEGORIES)
            r.status = szcls_pkg::ST_FULL;
        else
        begin
            cat_sizes[cat_count] = best[13:0];
            cat_valid[cat_count] = 1'b1;
            r.index   = cat_count[3:0];
            r.size    = best[13:0];
            r.created = 1'b1;
            cat_count++;
        end
        return r;
    endfunction

    task automatic send_request(input logic [13:0] sz);
        category_result_t r;
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            request_valid <= 1'b0;
            @(negedge clk);
        end
        request_valid <= 1'b1;
        request_size  <= sz;
        @(posedge clk);
        while (request_stall)
            @(posedge clk);
        r = predict_category(sz);
        pending_results.push_back(r);
        request_count++;
        status_count[r.status]++;
        if (r.created)
            created_count++;
    endtask

    task automatic test_size_limits();
        send_request(14'd0);
        send_request(14'd1);
        send_request(14'd23);
        send_request(14'd24);
        send_request(14'd16383);
        send_request(14'd8193);
        send_request(14'd8192);
        send_request(14'd8191);
        send_request(14'h2AAA);
        send_request(14'h1555);
    endtask

    task automatic test_rounding();
        send_request(14'd25);   // preferred 32
        send_request(14'd33);   // preferred 40
        send_request(14'd89);   // in-between 96 beats preferred 104
        send_request(14'd153);  // in-between 184
        send_request(14'd185);  // power of two 256
        send_request(14'd369);
        send_request(14'd32);   // exact reuse
        send_request(14'd24);
        send_request(14'd30);   // rounds to existing 32
        send_request(14'd100);
    endtask

    task automatic test_random();
        int pick;
        int sz;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 250 && n < 400);
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                sz = CLASS_EDGES[$urandom_range(NUM_EDGES - 1)] - $urandom_range(9);
                if (sz < 0)
                    sz = 0;
                sz = sz + $urandom_range(1);
            end
            else if (pick < 78)
                sz = $urandom_range(MAX_OBJECT_SIZE, szcls_pkg::MIN_REQUEST);
            else if (pick < 86)
                sz = $urandom_range(szcls_pkg::MIN_REQUEST - 1);
            else if (pick < 93)
                sz = $urandom_range(16383, MAX_OBJECT_SIZE + 1);
            else
                sz = $urandom_range(16383);
            send_request(sz[13:0]);
        end
        steady = 1'b0;
    endtask

    // result side: random back-pressure, quiet while the stimulus is steady
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: index %0d size %0d",
                       category_index, category_size);
                fail_count++;
            end
            else
            begin
                category_result_t want;
                want = pending_results.pop_front();
                if (category_index !== want.index)
                begin
                    $error("category_index: expected %0d, got %0d", want.index, category_index);
                    fail_count++;
                end
                if (category_size !== want.size)
                begin
                    $error("category_size: expected %0d, got %0d", want.size, category_size);
                    fail_count++;
                end
                if (was_created !== want.created)
                begin
                    $error("was_created: expected %0d, got %0d", want.created, was_created);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        request_valid = 1'b0;
        request_size  = '0;
        steady        = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        request_count = 0;
        created_count = 0;
        cat_count     = 0;
        for (int i = 0; i < 4; i++)
            status_count[i] = 0;
        for (int i = 0; i < MAX_CATEGORIES; i++)
        begin
            cat_sizes[i] = '0;
            cat_valid[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_size_limits();
        test_rounding();
        test_random();

        @(negedge clk);
        request_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d categories created, %0d served ok",
                 request_count, created_count, status_count[szcls_pkg::ST_OK]);
        $display("errors seen: %0d below minimum, %0d above maximum, %0d table full",
                 status_count[szcls_pkg::ST_BELOW], status_count[szcls_pkg::ST_ABOVE],
                 status_count[szcls_pkg::ST_FULL]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
sv/szcls_pkg.sv
sv/szcls_cell.sv
sv/size_class_selector_unit.sv
sim/size_class_selector_unit_tb.sv
